[hw/rtl/mts_pkg.sv]
// Package for the move-towards step clamp block.
// Shared status types between the front end, the queue and the top level.
// No dependencies.
`timescale 1ns / 1ps

package mts_pkg;

	// Queue fill status seen by the producer and the consumer
	typedef struct packed {
		logic full;
		logic empty;
	} mts_qstat_t;

endpackage

[hw/rtl/move_towards_step_clamp.sv]
// Move-towards with a bounded step: top level.
// Channels: s_tdata carries one point update request per transaction; m_tdata
// carries the next point, m_tuser the limited flag.
// An input transaction passes the front-end registers, the queue, the
// one-bit-per-stage square root and divide pipelines and the output register.
// Throughput: one transaction per cycle, every stage pipelined, unless m_tready stalls.
// The front end (differences, squares, clamp decision) feeds a two-entry queue;
// the back end pops it into the root/divide pipeline, which holds still while
// the output register waits on m_tready. When the queue is full and the front
// end's last stage holds a valid entry, the front end holds and s_tready drops.
// Reset clears all valid bits; no transaction is in flight afterwards.
// Depends on mts_pkg, mts_front, mts_queue and mts_back.
`timescale 1ns / 1ps

module move_towards_step_clamp #(
	parameter int COORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// current_x, current_y, target_x, target_y, max_step, zero fill
	input  logic [((5*COORD_BITS-1+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// next_x, next_y, zero fill
	output logic [((2*COORD_BITS+7)/8)*8-1:0]   m_tdata,
	// was_limited
	output logic m_tuser
);
	import mts_pkg::*;

	localparam int W  = COORD_BITS;
	localparam int QW = 9 * W + 6;
	localparam int OB = ((2*W+7)/8)*8;

	mts_qstat_t   q_stat;
	logic         push, pop;
	logic [QW-1:0] push_data, pop_data;
	logic [W-1:0] nx, ny;

	mts_front #(.W(W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.cx        (s_tdata[W-1:0]),
		.cy        (s_tdata[2*W-1:W]),
		.tx        (s_tdata[3*W-1:2*W]),
		.ty        (s_tdata[4*W-1:3*W]),
		.step      (s_tdata[5*W-2:4*W]),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	mts_queue #(.WIDTH(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	mts_back #(.W(W)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (!q_stat.empty),
		.q_data      (pop_data),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.next_x      (nx),
		.next_y      (ny),
		.was_limited (m_tuser)
	);

	assign m_tdata = OB'({ny, nx});

endmodule

[hw/rtl/mts_queue.sv]
// Two-entry register queue between the front end and the back end.
// Depends on mts_pkg for the status struct.
`timescale 1ns / 1ps

module mts_queue #(
	parameter int WIDTH = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [WIDTH-1:0]       push_data,
	input  logic                   pop,
	output logic [WIDTH-1:0]       pop_data,
	output mts_pkg::mts_qstat_t    stat
);
	import mts_pkg::*;

	logic [WIDTH-1:0] entry_q [0:1];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

[hw/rtl/mts_front.sv]
// Front end: differences, squares and the clamp decision.
// Depends on mts_pkg; feeds mts_queue.
`timescale 1ns / 1ps

module mts_front #(
	parameter int W = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [W-1:0]           cx,
	input  logic [W-1:0]           cy,
	input  logic [W-1:0]           tx,
	input  logic [W-1:0]           ty,
	input  logic [W-2:0]           step,
	input  mts_pkg::mts_qstat_t    q_stat,
	output logic                   push,
	output logic [9*W+5:0]         push_data
);
	import mts_pkg::*;

	localparam int SW = 2 * W + 2;

	typedef struct packed {
		logic [W-1:0] cx;
		logic [W-1:0] cy;
		logic [W-1:0] tx;
		logic [W-1:0] ty;
		logic [W:0]   ax;
		logic [W:0]   ay;
		logic         sx;
		logic         sy;
		logic [W-2:0] step;
		logic         lim;
	} ctx_t;

	logic         en;
	logic         v_s1, v_s2;
	logic [W-1:0] cx_s1, cy_s1, tx_s1, ty_s1, cx_s2, cy_s2, tx_s2, ty_s2;
	logic [W:0]   ax_s1, ay_s1, ax_s2, ay_s2;
	logic         sx_s1, sy_s1, sx_s2, sy_s2;
	logic [W-2:0] step_s1, step_s2;
	logic [SW-1:0]  axx_s2, ayy_s2;
	logic [2*W-3:0] ss_s2;
	logic [W:0]   dx, dy;
	logic [SW-1:0] d2;
	ctx_t         ctx;

	assign en       = !v_s2 || !q_stat.full;
	assign in_ready = en;
	assign push     = v_s2 && !q_stat.full;

	// exact differences and magnitudes
	assign dx = {tx[W-1], tx} - {cx[W-1], cx};
	assign dy = {ty[W-1], ty} - {cy[W-1], cy};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			cx_s1   <= cx;
			cy_s1   <= cy;
			tx_s1   <= tx;
			ty_s1   <= ty;
			step_s1 <= step;
			sx_s1   <= dx[W];
			sy_s1   <= dy[W];
			ax_s1   <= dx[W] ? (~dx + 1'b1) : dx;
			ay_s1   <= dy[W] ? (~dy + 1'b1) : dy;
			// squares
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			tx_s2   <= tx_s1;
			ty_s2   <= ty_s1;
			step_s2 <= step_s1;
			sx_s2   <= sx_s1;
			sy_s2   <= sy_s1;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			axx_s2  <= {{(W+1){1'b0}}, ax_s1} * {{(W+1){1'b0}}, ax_s1};
			ayy_s2  <= {{(W+1){1'b0}}, ay_s1} * {{(W+1){1'b0}}, ay_s1};
			ss_s2   <= {{(W-1){1'b0}}, step_s1} * {{(W-1){1'b0}}, step_s1};
		end
	end

	// squared distance and the clamp decision
	assign d2 = axx_s2 + ayy_s2;

	always_comb begin
		ctx.cx   = cx_s2;
		ctx.cy   = cy_s2;
		ctx.tx   = tx_s2;
		ctx.ty   = ty_s2;
		ctx.ax   = ax_s2;
		ctx.ay   = ay_s2;
		ctx.sx   = sx_s2;
		ctx.sy   = sy_s2;
		ctx.step = step_s2;
		ctx.lim  = (d2 > {4'b0000, ss_s2});
	end

	assign push_data = {ctx, d2};

endmodule

[hw/rtl/mts_back.sv]
// Back end: pipelined square root, scaling divide, final add with saturation.
// Depends on mts_pkg; consumes entries from mts_queue.
`timescale 1ns / 1ps

module mts_back #(
	parameter int W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  logic [9*W+5:0]   q_data,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [W-1:0]     next_x,
	output logic [W-1:0]     next_y,
	output logic             was_limited
);
	import mts_pkg::*;

	localparam int NB = W + 1;      // root bits
	localparam int SW = 2 * W + 2;  // radicand bits
	localparam int QB = W - 1;      // quotient bits
	localparam int NW = 2 * W + 2;  // dividend bits

	typedef struct packed {
		logic [W-1:0] cx;
		logic [W-1:0] cy;
		logic [W-1:0] tx;
		logic [W-1:0] ty;
		logic [W:0]   ax;
		logic [W:0]   ay;
		logic         sx;
		logic         sy;
		logic [W-2:0] step;
		logic         lim;
	} ctx_t;

	logic en;
	assign en  = !out_valid || out_ready;
	assign pop = en && q_valid;

	// square root pipeline, one root bit per stage
	logic          sq_v_s   [0:NB];
	logic [SW-1:0] sq_x_s   [0:NB];
	logic [SW-1:0] sq_r_s   [0:NB];
	ctx_t          sq_ctx_s [0:NB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (en) begin
			sq_v_s[0]   <= q_valid;
			sq_ctx_s[0] <= q_data[9*W+5:SW];
			sq_x_s[0]   <= q_data[SW-1:0];
			sq_r_s[0]   <= '0;
		end
	end

	for (genvar k = 0; k < NB; k++) begin : g_sqrt
		localparam logic [SW-1:0] ONE = SW'(1) << (2 * (NB - 1 - k));
		logic [SW-1:0] trial;
		logic          take;
		assign trial = sq_r_s[k] + ONE;
		assign take  = (sq_x_s[k] >= trial);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1]   <= sq_v_s[k];
				sq_ctx_s[k+1] <= sq_ctx_s[k];
				sq_x_s[k+1]   <= take ? (sq_x_s[k] - trial) : sq_x_s[k];
				sq_r_s[k+1]   <= take ? ((sq_r_s[k] >> 1) + ONE) : (sq_r_s[k] >> 1);
			end
		end
	end

	// length and step-scaled numerators
	logic [W:0]     root;
	logic           mul_v_s;
	ctx_t           mul_ctx_s;
	logic [W:0]     mul_len_s;
	logic [2*W-1:0] mul_px_s, mul_py_s;

	assign root = sq_r_s[NB][W:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s <= 1'b0;
		end else if (en) begin
			mul_v_s   <= sq_v_s[NB];
			mul_ctx_s <= sq_ctx_s[NB];
			mul_len_s <= (root == '0) ? (W+1)'(1) : root;
			mul_px_s  <= {{(W-1){1'b0}}, sq_ctx_s[NB].ax} *
			             {{(W+1){1'b0}}, sq_ctx_s[NB].step};
			mul_py_s  <= {{(W-1){1'b0}}, sq_ctx_s[NB].ay} *
			             {{(W+1){1'b0}}, sq_ctx_s[NB].step};
		end
	end

	// rounding divide, one quotient bit per stage, x and y lanes
	logic          dv_v_s   [0:QB];
	ctx_t          dv_ctx_s [0:QB];
	logic [W+1:0]  dv_d_s   [0:QB];
	logic [NW-1:0] dv_rx_s  [0:QB];
	logic [NW-1:0] dv_ry_s  [0:QB];
	logic [QB-1:0] dv_qx_s  [0:QB];
	logic [QB-1:0] dv_qy_s  [0:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0]   <= mul_v_s;
			dv_ctx_s[0] <= mul_ctx_s;
			dv_d_s[0]   <= {mul_len_s, 1'b0};
			dv_rx_s[0]  <= {1'b0, mul_px_s, 1'b0} + {{(W+1){1'b0}}, mul_len_s};
			dv_ry_s[0]  <= {1'b0, mul_py_s, 1'b0} + {{(W+1){1'b0}}, mul_len_s};
			dv_qx_s[0]  <= '0;
			dv_qy_s[0]  <= '0;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int B = QB - 1 - j;
		logic [NW-1:0] dsh;
		logic          gx, gy;
		assign dsh = {{W{1'b0}}, dv_d_s[j]} << B;
		assign gx  = (dv_rx_s[j] >= dsh);
		assign gy  = (dv_ry_s[j] >= dsh);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[j+1]   <= dv_v_s[j];
				dv_ctx_s[j+1] <= dv_ctx_s[j];
				dv_d_s[j+1]   <= dv_d_s[j];
				dv_rx_s[j+1]  <= gx ? (dv_rx_s[j] - dsh) : dv_rx_s[j];
				dv_ry_s[j+1]  <= gy ? (dv_ry_s[j] - dsh) : dv_ry_s[j];
				dv_qx_s[j+1]  <= dv_qx_s[j] | (QB'(gx) << B);
				dv_qy_s[j+1]  <= dv_qy_s[j] | (QB'(gy) << B);
			end
		end
	end

	// signed move, add and saturate
	ctx_t       fc;
	logic [W:0] qxe, qye, mvx, mvy, sumx, sumy;
	logic [W-1:0] satx, saty;
	localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	assign fc   = dv_ctx_s[QB];
	assign qxe  = {2'b00, dv_qx_s[QB]};
	assign qye  = {2'b00, dv_qy_s[QB]};
	assign mvx  = fc.sx ? (~qxe + 1'b1) : qxe;
	assign mvy  = fc.sy ? (~qye + 1'b1) : qye;
	assign sumx = {fc.cx[W-1], fc.cx} + mvx;
	assign sumy = {fc.cy[W-1], fc.cy} + mvy;
	assign satx = (sumx[W] != sumx[W-1]) ? (sumx[W] ? SMIN : SMAX) : sumx[W-1:0];
	assign saty = (sumy[W] != sumy[W-1]) ? (sumy[W] ? SMIN : SMAX) : sumy[W-1:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid   <= dv_v_s[QB];
			next_x      <= fc.lim ? satx : fc.tx;
			next_y      <= fc.lim ? saty : fc.ty;
			was_limited <= fc.lim;
		end
	end

endmodule

[hw/rtl/mts_checker.sv]
// Port-level checker for move_towards_step_clamp, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module mts_checker #(
	parameter int COORD_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [((5*COORD_BITS-1+7)/8)*8-1:0] s_tdata,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((2*COORD_BITS+7)/8)*8-1:0]   m_tdata,
	input logic m_tuser
);

	// a waiting result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	// a waiting result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// nothing is offered right out of reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result offered right after reset");

	// the input only backs up after the output stalled
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> $past(m_tvalid && !m_tready))
		else $error("input stalled without an output stall");

endmodule

bind move_towards_step_clamp mts_checker #(.COORD_BITS(COORD_BITS)) u_chk (.*);
